FILE: design/gslfu_pkg.sv
package gslfu_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int GLYPH_W       = 8;
  localparam int USAGE_W       = 8;
  localparam int SLOT_OUT_W    = 3;

  localparam logic [GLYPH_W-1:0] EMPTY_TAG  = 8'hFF;
  localparam logic [USAGE_W-1:0] USAGE_MAX  = 8'hFF;
  localparam logic [USAGE_W-1:0] USAGE_INIT = 8'd1;
  localparam logic [USAGE_W-1:0] USAGE_RST  = 8'd0;

  typedef struct packed {
    logic [GLYPH_W-1:0] tag;
    logic [USAGE_W-1:0] usage;
  } slot_ent_t;

  localparam slot_ent_t EMPTY_ENT = '{tag: EMPTY_TAG, usage: USAGE_RST};

  typedef struct packed {
    logic                  evicted;
    logic                  need_load;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
  } gslfu_res_t;

endpackage

FILE: design/glyph_slot_lfu_cache.sv
// A request runs through the scan, last and write states; the scan sweeps every slot
// through the single read port of the slot memory, and a request with the reserved
// empty index goes straight to write. Write pushes the result into the output register
// once it is free; a new request is accepted only when the block is back in idle.
// Reset: synchronous active-low rst_n clears the slot valid bits (all slots read as
// empty with zero usage), the sequencer and the output valid flag.
module glyph_slot_lfu_cache
  import gslfu_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] glyph_index
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] slot, [3] hit, [4] need_load, [5] evicted, [7:6] zero
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  logic              out_free;
  logic              res_push;
  gslfu_res_t        res;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  slot_ent_t         rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_ent_t         wr_data;
  logic              out_valid_r;
  gslfu_res_t        out_res_r;

  gslfu_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_glyph (in_tdata[GLYPH_W-1:0]),
    .in_ready (in_tready),
    .out_free (out_free),
    .res_push (res_push),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  gslfu_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
      out_res_r   <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!out_valid_r || out_tready))
    else $error("result pushed into occupied output register");

  a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.hit) |-> (!res.need_load && !res.evicted && wr_en))
    else $error("hit result flags a load");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_write_push: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (res_push && (res.hit || res.need_load)))
    else $error("slot write without a matching result");

endmodule

FILE: design/gslfu_slot_mem.sv
module gslfu_slot_mem
  import gslfu_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_ent_t         rd_data,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  slot_ent_t         wr_data
);

  slot_ent_t             mem_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  valid_r;
  slot_ent_t             rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries read as empty
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : EMPTY_ENT;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/gslfu_ctrl.sv
module gslfu_ctrl
  import gslfu_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [GLYPH_W-1:0] in_glyph,
  output logic               in_ready,
  input  logic               out_free,
  output logic               res_push,
  output gslfu_res_t         res,
  output logic               rd_en,
  output logic [SLOT_W-1:0]  rd_addr,
  input  slot_ent_t          rd_data,
  output logic               wr_en,
  output logic [SLOT_W-1:0]  wr_addr,
  output slot_ent_t          wr_data
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_t;

  state_t              state_r;
  logic [SLOT_W-1:0]   cnt_r;
  logic                chk_vld_r;
  logic [SLOT_W-1:0]   chk_idx_r;
  logic [GLYPH_W-1:0]  glyph_r;
  logic                ign_r;
  logic                hit_r;
  logic [SLOT_W-1:0]   hit_idx_r;
  logic [USAGE_W-1:0]  hit_use_r;
  logic                emp_r;
  logic [SLOT_W-1:0]   emp_idx_r;
  logic [USAGE_W-1:0]  min_use_r;
  logic [SLOT_W-1:0]   min_idx_r;
  logic [SLOT_W+2:0]   slot_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chk_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      chk_vld_r <= rd_en;
      chk_idx_r <= rd_addr;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            glyph_r <= in_glyph;
            ign_r   <= (in_glyph == EMPTY_TAG);
            hit_r   <= 1'b0;
            emp_r   <= 1'b0;
            cnt_r   <= '0;
            state_r <= (in_glyph == EMPTY_TAG) ? ST_WRITE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + SLOT_W'(1);
          if (cnt_r == LAST_IDX) begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (chk_vld_r) begin
        if (!hit_r && rd_data.tag == glyph_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= chk_idx_r;
          hit_use_r <= rd_data.usage;
        end
        if (!emp_r && rd_data.tag == EMPTY_TAG) begin
          emp_r     <= 1'b1;
          emp_idx_r <= chk_idx_r;
        end
        if (chk_idx_r == '0 || rd_data.usage < min_use_r) begin
          min_use_r <= rd_data.usage;
          min_idx_r <= chk_idx_r;
        end
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign rd_en    = (state_r == ST_SCAN);
  assign rd_addr  = cnt_r;
  assign res_push = (state_r == ST_WRITE) && out_free;
  assign wr_en    = res_push && !ign_r;

  always_comb begin
    priority if (hit_r) begin
      wr_addr = hit_idx_r;
    end else if (emp_r) begin
      wr_addr = emp_idx_r;
    end else begin
      wr_addr = min_idx_r;
    end
  end

  always_comb begin
    wr_data.tag = glyph_r;
    if (hit_r) begin
      wr_data.usage = (hit_use_r == USAGE_MAX) ? hit_use_r : hit_use_r + USAGE_W'(1);
    end else begin
      wr_data.usage = USAGE_INIT;
    end
  end

  assign slot_ext = {3'b000, wr_addr};

  always_comb begin
    if (ign_r) begin
      res = '0;
    end else begin
      res.slot      = slot_ext[SLOT_OUT_W-1:0];
      res.hit       = hit_r;
      res.need_load = !hit_r;
      res.evicted   = !hit_r && !emp_r;
    end
  end

endmodule
